[rtl/ape_pkg.sv]
// shared types and constants for the ambisonic panning encoder
`default_nettype none

package ape_pkg;

   // input transfer payload
   typedef struct packed {
      logic signed [15:0] sample_in;
      logic [15:0]        azimuth;
      logic [15:0]        elevation;
   } req_type;

   // result transfer payload
   typedef struct packed {
      logic signed [15:0] out_w;
      logic signed [15:0] out_x;
      logic signed [15:0] out_y;
      logic signed [15:0] out_z;
      logic signed [15:0] out_u;
      logic signed [15:0] out_v;
      logic signed [15:0] out_p;
      logic signed [15:0] out_q;
   } rsp_type;

   // per-stage load enables of the lookup/multiply pipeline
   typedef struct packed {
      logic load_s1;
      logic load_s2;
      logic load_s3;
      logic load_s4;
   } stage_en_type;

   // 17-bit phase, 2^17 is one turn; top two bits are the quadrant
   typedef logic [16:0] phase_type;

   localparam phase_type PHASE_QUARTER = 17'h08000;

   // order register codes
   localparam logic [1:0] ORDER_NONE   = 2'd0;
   localparam logic [1:0] ORDER_FIRST  = 2'd1;
   localparam logic [1:0] ORDER_SECOND = 2'd2;
   localparam logic [1:0] ORDER_THIRD  = 2'd3;

   // channel slots
   localparam int CH_W     = 0;
   localparam int CH_X     = 1;
   localparam int CH_Y     = 2;
   localparam int CH_Z     = 3;
   localparam int CH_U     = 4;
   localparam int CH_V     = 5;
   localparam int CH_P     = 6;
   localparam int CH_Q     = 7;
   localparam int CH_COUNT = 8;

   localparam logic signed [15:0] W_GAIN = 16'sd23167;

   // pi/2 in Q2.30
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

endpackage

`default_nettype wire

[rtl/ape_sine.sv]
// sine lane: table index, quarter-wave rom read and quadrant sign
`default_nettype none

module ape_sine #(
   parameter int SINE_TABLE_DEPTH = 256
) (
   input  wire                        clock,
   input  wire ape_pkg::phase_type    phase_in,
   input  wire ape_pkg::stage_en_type stage_en,
   output logic signed [15:0]         coef
);
   import ape_pkg::*;

   localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int SCALE_W = 15 + IDX_W;

   // quarter-wave entry k in Q1.15, taylor series to the 13th power
   function automatic logic [14:0] rom_value(input int k);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        r;
      x    = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      term = ((term * x2) >> 30) / 6;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 20;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 42;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 72;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 110;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 156;
      sum  = sum + $signed(term);
      if (sum < 0) begin
         sum = 0;
      end
      r = ($unsigned(sum) * 64'd32767 + 64'd536870912) >> 30;
      if (r > 64'd32767) begin
         r = 64'd32767;
      end
      return r[14:0];
   endfunction

   logic [14:0] rom_mem [0:SINE_TABLE_DEPTH];

   for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
      assign rom_mem[k] = rom_value(k);
   end

   logic [SCALE_W-1:0] scaled;
   logic [IDX_W-1:0]   idx_in;
   logic [IDX_W-1:0]   idx_ff;
   logic [1:0]         quad_ff;
   logic [IDX_W-1:0]   addr;
   logic [14:0]        rom_q_ff;
   logic               neg_ff;

   // nearest table step of the position inside the quadrant
   assign scaled = SCALE_W'(phase_in[14:0]) * SCALE_W'(SINE_TABLE_DEPTH)
                 + SCALE_W'(16384);
   assign idx_in = scaled[SCALE_W-1:15];

   always_ff @(posedge clock) begin
      if (stage_en.load_s1) begin
         idx_ff  <= idx_in;
         quad_ff <= phase_in[16:15];
      end
   end

   // odd quadrants run the table backward
   assign addr = quad_ff[0] ? (IDX_W'(SINE_TABLE_DEPTH) - idx_ff) : idx_ff;

   always_ff @(posedge clock) begin
      if (stage_en.load_s2) begin
         rom_q_ff <= rom_mem[addr];
         neg_ff   <= quad_ff[1];
      end
   end

   assign coef = neg_ff ? -$signed({1'b0, rom_q_ff}) : $signed({1'b0, rom_q_ff});

endmodule

`default_nettype wire

[rtl/ape_scale.sv]
// channel gain: sample times coefficient, round half up and saturate to q1.15, or zero when keep is low
`default_nettype none

module ape_scale (
   input  wire                        clock,
   input  wire signed [15:0]          sample,
   input  wire signed [15:0]          coef,
   input  wire                        keep,
   input  wire ape_pkg::stage_en_type stage_en,
   output logic signed [15:0]         result
);
   import ape_pkg::*;

   logic signed [31:0] prod_ff;
   logic signed [32:0] rnd;
   logic signed [17:0] shifted;
   logic signed [15:0] sat;
   logic signed [15:0] result_ff;

   always_ff @(posedge clock) begin
      if (stage_en.load_s3) begin
         prod_ff <= sample * coef;
      end
   end

   assign rnd     = $signed({prod_ff[31], prod_ff}) + 33'sd16384;
   assign shifted = rnd[32:15];

   always_comb begin
      if (shifted > 18'sd32767) begin
         sat = 16'sh7fff;
      end else if (shifted < -18'sd32768) begin
         sat = 16'sh8000;
      end else begin
         sat = shifted[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.load_s4) begin
         result_ff <= keep ? sat : 16'sd0;
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire

[rtl/ambisonic_panning_encoder.sv]
// ambisonic panning encoder top level: pipeline control, phases and channel lanes
//
//   channel  ports                          carries
//   req      req_valid/req_ready/req_data   sample, azimuth, elevation
//   rsp      rsp_valid/rsp_ready/rsp_data   w x y z u v p q channels
//   csr      csr_wr_en/csr_wr_data          order register
//
// one item per cycle while the output is not stalled; the stages, in order, are
// table index, rom read, multiply, round/saturate into the output register.
// each stage moves when the next one is empty or moving, so bubbles close up
// and new items are taken while a result waits in the output register.
// reset clears the stage valids and sets order to one; no clearing pass.
`default_nettype none

module ambisonic_panning_encoder #(
   parameter int SINE_TABLE_DEPTH = 256
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  wire ape_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output ape_pkg::rsp_type       rsp_data,
   input  wire                    csr_wr_en,
   input  wire [1:0]              csr_wr_data
);
   import ape_pkg::*;

   logic [1:0]   order_ff;
   logic         v1_ff, v2_ff, v3_ff, v4_ff;
   logic         v1_in, v2_in, v3_in, v4_in;
   stage_en_type stage_en;

   logic signed [15:0] s1_ff;
   logic signed [15:0] s2_ff;

   logic [15:0]  az2;
   logic [15:0]  az3;
   phase_type    phase [CH_COUNT];
   logic signed [15:0] coef   [CH_COUNT];
   logic signed [15:0] result [CH_COUNT];
   logic         keep   [CH_COUNT];

   // stage enables, back from the output register
   always_comb begin
      stage_en.load_s4 = v3_ff && (!v4_ff || rsp_ready);
      stage_en.load_s3 = v2_ff && (!v3_ff || stage_en.load_s4);
      stage_en.load_s2 = v1_ff && (!v2_ff || stage_en.load_s3);
      req_ready        = !v1_ff || stage_en.load_s2;
      stage_en.load_s1 = req_valid && req_ready;
      v1_in = stage_en.load_s1 || (v1_ff && !stage_en.load_s2);
      v2_in = stage_en.load_s2 || (v2_ff && !stage_en.load_s3);
      v3_in = stage_en.load_s3 || (v3_ff && !stage_en.load_s4);
      v4_in = stage_en.load_s4 || (v4_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= ORDER_FIRST;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            order_ff <= csr_wr_data;
         end
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.load_s1) begin
         s1_ff <= req_data.sample_in;
      end
      if (stage_en.load_s2) begin
         s2_ff <= s1_ff;
      end
   end

   // phases; cosine is a quarter turn ahead
   assign az2 = {req_data.azimuth[14:0], 1'b0};
   assign az3 = req_data.azimuth + az2;

   always_comb begin
      phase[CH_W] = '0;
      phase[CH_X] = {req_data.azimuth, 1'b0} + PHASE_QUARTER;
      phase[CH_Y] = {req_data.azimuth, 1'b0};
      phase[CH_Z] = {1'b0, req_data.elevation} - PHASE_QUARTER;
      phase[CH_U] = {az2, 1'b0} + PHASE_QUARTER;
      phase[CH_V] = {az2, 1'b0};
      phase[CH_P] = {az3, 1'b0} + PHASE_QUARTER;
      phase[CH_Q] = {az3, 1'b0};
   end

   // order zero behaves as order one
   always_comb begin
      keep[CH_W] = 1'b1;
      keep[CH_X] = 1'b1;
      keep[CH_Y] = 1'b1;
      keep[CH_Z] = (order_ff == ORDER_NONE) || (order_ff == ORDER_FIRST);
      keep[CH_U] = (order_ff == ORDER_SECOND) || (order_ff == ORDER_THIRD);
      keep[CH_V] = keep[CH_U];
      keep[CH_P] = (order_ff == ORDER_THIRD);
      keep[CH_Q] = keep[CH_P];
   end

   assign coef[CH_W] = W_GAIN;

   for (genvar c = CH_X; c < CH_COUNT; c++) begin : g_sine
      ape_sine #(
         .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
      ) u_sine (
         .clock    (clock),
         .phase_in (phase[c]),
         .stage_en (stage_en),
         .coef     (coef[c])
      );
   end

   for (genvar c = CH_W; c < CH_COUNT; c++) begin : g_scale
      ape_scale u_scale (
         .clock    (clock),
         .sample   (s2_ff),
         .coef     (coef[c]),
         .keep     (keep[c]),
         .stage_en (stage_en),
         .result   (result[c])
      );
   end

   assign rsp_valid      = v4_ff;
   assign rsp_data.out_w = result[CH_W];
   assign rsp_data.out_x = result[CH_X];
   assign rsp_data.out_y = result[CH_Y];
   assign rsp_data.out_z = result[CH_Z];
   assign rsp_data.out_u = result[CH_U];
   assign rsp_data.out_v = result[CH_V];
   assign rsp_data.out_p = result[CH_P];
   assign rsp_data.out_q = result[CH_Q];

   // an item entering an empty pipeline reaches the output without waiting in any stage
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !v1_ff && !v2_ff && !v3_ff && !v4_ff |-> ##4 rsp_valid)
      else $error("item lost or delayed in empty pipeline");

   // a full pipeline can only take an item when the output drains
   assert property (@(posedge clock) disable iff (reset)
      req_ready && v1_ff && v2_ff && v3_ff && v4_ff |-> rsp_ready)
      else $error("full pipeline accepted without draining");

   // w is the sample times the omni gain, so its magnitude is bounded
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.out_w <= W_GAIN) && (rsp_data.out_w >= -W_GAIN))
      else $error("w channel out of gain range");

endmodule

`default_nettype wire

[test/tb.sv]
// self-checking testbench for the ambisonic panning encoder
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ape_pkg::*;

   localparam int TABLE_DEPTH = 256;
   localparam int RESET_CYCLES = 9;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES = 200;
   localparam int IDLE_PCT = 33;
   localparam int PRINT_LIMIT = 100;
   localparam int DIRECTED_COUNT = 20;
   localparam int FIRST_ORDER_ITEMS = 12;
   localparam int PHASE_COUNT = 8;
   localparam int STEADY_PHASE = 2;
   localparam int HOLD_PHASE = 3;
   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

   // sample, azimuth, elevation
   localparam logic [47:0] DIRECTED_ITEMS [DIRECTED_COUNT] = '{
      48'h7FFF_0000_0000, 48'h8000_0000_FFFF, 48'h7FFF_4000_8000, 48'h8000_8000_4000,
      48'h0001_C000_C000, 48'hFFFF_FFFF_0001, 48'h0000_2000_7FFF, 48'h7FFF_0080_8080,
      48'h8000_FF80_0000, 48'h5A5A_A5A5_5A5A, 48'hA5A5_5A5A_A5A5, 48'h7FFF_E000_FFFF,
      48'h7FFF_5555_0000, 48'h8000_AAAA_FFFF, 48'h7FFF_1000_8000, 48'h8000_3000_0000,
      48'h7FFF_C000_1234, 48'h8000_FFFF_FFFF, 48'h0001_0001_0000, 48'h7FFF_2AAB_0000
   };

   localparam logic [1:0] PHASE_ORDERS [PHASE_COUNT] = '{
      ORDER_SECOND, ORDER_NONE, ORDER_THIRD, ORDER_FIRST,
      ORDER_THIRD, ORDER_SECOND, ORDER_FIRST, ORDER_NONE
   };

   class channel_scoreboard;
      rsp_type     expected_q[$];
      logic [1:0]  order_reg;
      int unsigned mismatches;
      int          quarter_wave[TABLE_DEPTH+1];

      function new();
         bit [63:0] x, x2, term, rounded;
         longint    sum;
         // quarter-wave rom from a seven-term taylor series in q2.30
         for (int k = 0; k <= TABLE_DEPTH; k++) begin
            x = (HALF_PI_Q30 * 64'(k)) / 64'(TABLE_DEPTH);
            x2 = (x * x) >> 30;
            term = x;
            sum = longint'(x);
            for (int n = 1; n <= 6; n++) begin
               term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
               if (n % 2 == 1)
                  sum -= longint'(term);
               else
                  sum += longint'(term);
            end
            if (sum < 0)
               sum = 0;
            rounded = (64'(sum) * 64'd32767 + 64'h2000_0000) >> 30;
            quarter_wave[k] = (rounded > 32767) ? 32767 : int'(rounded);
         end
         order_reg = ORDER_FIRST;
         mismatches = 0;
      endfunction

      function int sine_of(bit [31:0] phase);
         bit [63:0] idx;
         int        i;
         idx = (64'(phase[29:0]) * TABLE_DEPTH + 64'h2000_0000) >> 30;
         i = (idx > TABLE_DEPTH) ? TABLE_DEPTH : int'(idx);
         case (phase[31:30])
            2'd0: return quarter_wave[i];
            2'd1: return quarter_wave[TABLE_DEPTH - i];
            2'd2: return -quarter_wave[i];
            default: return -quarter_wave[TABLE_DEPTH - i];
         endcase
      endfunction

      function logic signed [15:0] scale_q15(int s, int c);
         longint p;
         p = (longint'(s) * longint'(c) + 16384) >>> 15;
         if (p > 32767)
            p = 32767;
         else if (p < -32768)
            p = -32768;
         return p[15:0];
      endfunction

      function void note_sample(req_type item);
         int         s;
         bit [31:0]  ph1, ph2, ph3, phe;
         logic [1:0] ord;
         rsp_type    want;
         s = $signed(item.sample_in);
         ph1 = {item.azimuth, 16'h0};
         ph2 = ph1 << 1;
         ph3 = ph1 + ph2;
         phe = {1'b0, item.elevation, 15'h0} - QUARTER_TURN;
         ord = (order_reg == ORDER_NONE) ? ORDER_FIRST : order_reg;
         want = '0;
         want.out_w = scale_q15(s, W_GAIN);
         want.out_x = scale_q15(s, sine_of(ph1 + QUARTER_TURN));
         want.out_y = scale_q15(s, sine_of(ph1));
         if (ord == ORDER_FIRST)
            want.out_z = scale_q15(s, sine_of(phe));
         else begin
            want.out_u = scale_q15(s, sine_of(ph2 + QUARTER_TURN));
            want.out_v = scale_q15(s, sine_of(ph2));
         end
         if (ord == ORDER_THIRD) begin
            want.out_p = scale_q15(s, sine_of(ph3 + QUARTER_TURN));
            want.out_q = scale_q15(s, sine_of(ph3));
         end
         expected_q.push_back(want);
      endfunction

      task report_mismatch(string msg);
         if (mismatches < PRINT_LIMIT)
            $display("%0t mismatch: %s", $time, msg);
         mismatches++;
      endtask

      task check_channels(rsp_type got);
         rsp_type                     want;
         logic [CH_COUNT-1:0][15:0]   got_ch, want_ch;
         string                       letters;
         letters = "wxyzuvpq";
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("result %h with nothing pending", got));
            return;
         end
         want = expected_q.pop_front();
         got_ch = got;
         want_ch = want;
         // out_w is the top slice of the packed struct
         for (int j = 0; j < CH_COUNT; j++)
            if (got_ch[CH_COUNT-1-j] !== want_ch[CH_COUNT-1-j])
               report_mismatch($sformatf("out_%c got %0d want %0d", letters[j],
                  $signed(got_ch[CH_COUNT-1-j]), $signed(want_ch[CH_COUNT-1-j])));
      endtask

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_data;
   logic       csr_wr_en = 1'b0;
   logic [1:0] csr_wr_data = ORDER_NONE;

   int         idle_pct = IDLE_PCT;
   int         hold_requests = 0;
   int         hold_seen = 0;
   int         hold_left = 0;

   channel_scoreboard sb;

   ambisonic_panning_encoder i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // result side: random back-pressure plus a long hold-off when the stimulus asks for one
   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else if (hold_requests != hold_seen) begin
         hold_seen <= hold_requests;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else
         rsp_ready <= ($urandom_range(0, 99) >= idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_sample(req_data);
         if (rsp_valid && rsp_ready)
            sb.check_channels(rsp_data);
      end
   end

   function automatic req_type random_item();
      req_type item;
      item.sample_in = 16'($urandom());
      if ($urandom_range(0, 7) == 0)
         item.sample_in = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      item.azimuth = 16'($urandom());
      // land near octant boundaries, where twice the azimuth wraps onto quadrant edges
      if ($urandom_range(0, 5) == 0)
         item.azimuth = 16'($urandom_range(0, 7) << 13) + 16'($urandom_range(0, 2)) - 16'd1;
      item.elevation = 16'($urandom());
      if ($urandom_range(0, 7) == 0)
         case ($urandom_range(0, 2))
            0: item.elevation = 16'h0000;
            1: item.elevation = 16'h8000;
            default: item.elevation = 16'hFFFF;
         endcase
      return item;
   endfunction

   task automatic send_item(req_type item);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_order(logic [1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.order_reg = value;
   endtask

   initial begin
      int burst;
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners: first under the reset order, then at third order
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         if (i == FIRST_ORDER_ITEMS) begin
            drain_pipeline();
            write_order(ORDER_THIRD);
         end
         send_item(req_type'(DIRECTED_ITEMS[i]));
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         drain_pipeline();
         write_order(PHASE_ORDERS[p]);
         idle_pct <= (p == STEADY_PHASE) ? 0 : IDLE_PCT;
         if (p == HOLD_PHASE)
            hold_requests <= hold_requests + 1;
         burst = $urandom_range(120, 160);
         for (int n = 0; n < burst; n++)
            send_item(random_item());
      end
      drain_pipeline();

      if (sb.mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

[filelist.f]
rtl/ape_pkg.sv
rtl/ape_sine.sv
rtl/ape_scale.sv
rtl/ambisonic_panning_encoder.sv
test/tb.sv
